/* rtl/assert_macros.svh */
// Assertion helpers shared by the calendar arithmetic RTL.
// Each macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/calda_pkg.sv */
// ----------------------------------------------------------------------------
// calda_pkg
// Widths, calendar constants and month tables for the Gregorian date
// arithmetic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package calda_pkg;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 23;
  localparam int DIFF_W  = 23;
  localparam int DOY_W   = 9;   // day of March-based year, 0..365
  localparam int ZR_W    = 22;  // raw day number of a valid date
  localparam int F_W     = 23;  // day count of any 14-bit year
  localparam int Z_W     = 24;  // signed raw day number plus offset
  localparam int BIT_W   = $clog2(YEAR_W);

  // Reciprocal of 100: floor(x / 100) == (x * 5243) >> 19 for x < 43690
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int P100_W = YEAR_W + RECIP_W;
  localparam int P400_W = YEAR_W - 2 + RECIP_W;
  localparam int Q100_W = P100_W - RECIP_SH;
  localparam int Q400_W = P400_W - RECIP_SH;
  localparam int R100_W = Q100_W + 7;

  localparam logic [F_W-1:0]    DAYS_YEAR = 23'd365;
  localparam logic [R100_W-1:0] CENTURY   = 15'd100;

  // Calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
  localparam logic [DOY_W-1:0]   DOY_MAX   = 9'd365;
  // March-based month index of January; January and February follow December
  localparam logic [MONTH_W-1:0] MP_JAN    = 4'd10;
  localparam logic [MONTH_W-1:0] MP_WRAP   = 4'd9;

  // Raw day numbers of 0001-01-01 and 9999-12-31
  localparam logic [ZR_W-1:0] RAW_MIN = 22'd306;
  localparam logic [ZR_W-1:0] RAW_MAX = 22'd3652364;

  typedef enum logic {
    OP_SHIFT = 1'b0,
    OP_DIFF  = 1'b1
  } op_t;

  // Result of the shared day-count unit
  typedef struct packed {
    logic [F_W-1:0] f;     // days from March 1 of year 0 to March 1 of year c
    logic           leap;  // operand is a leap year
  } unit_res_t;

  // First day of each month within a year that starts on March 1
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Length of calendar month m (1..12)
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/calda_cmd_if.sv */
// ----------------------------------------------------------------------------
// calda_cmd_if
// Request channel: operation code, two dates and a signed day offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface calda_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [calda_pkg::YEAR_W-1:0]        year_a;
  logic [calda_pkg::MONTH_W-1:0]       month_a;
  logic [calda_pkg::DAY_W-1:0]         day_a;
  logic signed [calda_pkg::OFF_W-1:0]  offset;
  logic [calda_pkg::YEAR_W-1:0]        year_b;
  logic [calda_pkg::MONTH_W-1:0]       month_b;
  logic [calda_pkg::DAY_W-1:0]         day_b;

  modport source (
    output valid, op, year_a, month_a, day_a, offset, year_b, month_b, day_b,
    input  ready
  );

  modport sink (
    input  valid, op, year_a, month_a, day_a, offset, year_b, month_b, day_b,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/calda_res_if.sv */
// ----------------------------------------------------------------------------
// calda_res_if
// Result channel: shifted date, day difference and comparison flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface calda_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [calda_pkg::YEAR_W-1:0]         year_out;
  logic [calda_pkg::MONTH_W-1:0]        month_out;
  logic [calda_pkg::DAY_W-1:0]          day_out;
  logic signed [calda_pkg::DIFF_W-1:0]  difference;
  logic                                 a_after_b;
  logic                                 dates_equal;
  logic                                 out_of_range;

  modport source (
    output valid, year_out, month_out, day_out, difference, a_after_b, dates_equal,
           out_of_range,
    input  ready
  );

  modport sink (
    input  valid, year_out, month_out, day_out, difference, a_after_b, dates_equal,
           out_of_range,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/calda_unit.sv */
// ----------------------------------------------------------------------------
// calda_unit
// Shared day-count unit: registers the products of a year operand, then
// sums them into the day count up to that year and flags leap years.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calda_unit (
  input  logic                         clk,
  input  logic [calda_pkg::YEAR_W-1:0] c,
  output calda_pkg::unit_res_t         res
);
  import calda_pkg::*;

  logic [P100_W-1:0] prod100;
  logic [P400_W-1:0] prod400;
  logic [YEAR_W-1:0] opnd;
  logic [Q100_W-1:0] q100;
  logic [Q400_W-1:0] q400;
  logic [F_W-1:0]    m365;
  logic [R100_W-1:0] r100;
  logic              cent_exact;

  // Divide by 100 and by 400 through the reciprocal
  always_comb begin
    prod100 = P100_W'(c) * P100_W'(RECIP_100);
    prod400 = P400_W'(c[YEAR_W-1:2]) * P400_W'(RECIP_100);
  end

  // Hold the operand and its partial results
  always_ff @(posedge clk) begin
    opnd <= c;
    q100 <= prod100[RECIP_SH +: Q100_W];
    q400 <= prod400[RECIP_SH +: Q400_W];
    m365 <= F_W'(c) * DAYS_YEAR;
  end

  // 365y + y/4 - y/100 + y/400
  assign res.f = m365 + F_W'(opnd[YEAR_W-1:2]) - F_W'(q100) + F_W'(q400);

  // Leap when divisible by 4, except centuries not divisible by 400
  always_comb begin
    r100       = R100_W'(q100) * CENTURY;
    cent_exact = (r100 == R100_W'(opnd));
    res.leap   = (opnd[1:0] == 2'b00) && (!cent_exact || (q100[1:0] == 2'b00));
  end

endmodule

`default_nettype wire

/* rtl/calendar_date_arithmetic.sv */
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Gregorian date shift and day difference over years 1 to 9999.
// ----------------------------------------------------------------------------
// Each request carries two dates and a signed offset. Dates outside the
// calendar are first pulled to the nearest valid date (year, then month, then
// day). A shift (op 0) adds the offset to date A and returns the new date,
// pinned to 0001-01-01 or 9999-12-31 with out_of_range set when it leaves the
// calendar; a difference (op 1) returns the days from B to A. Both report
// whether A is after B and whether they are equal. One request is in flight
// at a time. A shift then runs a year search of 14 steps, each loading a
// candidate year into the single day-count unit and testing it; a difference
// skips the search. A finished result sits in the output register while the
// next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module calendar_date_arithmetic (
  input  logic   clk,
  input  logic   rst,
  calda_cmd_if.sink   cmd,
  calda_res_if.source res
);
  import calda_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_LA    = 13'b0000000000010,
    S_DA    = 13'b0000000000100,
    S_FA    = 13'b0000000001000,
    S_DB    = 13'b0000000010000,
    S_FB    = 13'b0000000100000,
    S_CMP   = 13'b0000001000000,
    S_LOAD  = 13'b0000010000000,
    S_TEST  = 13'b0000100000000,
    S_FLOAD = 13'b0001000000000,
    S_CONV  = 13'b0010000000000,
    S_MD    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // Request registers
  op_t                     op_r;
  logic signed [OFF_W-1:0] off_r;
  logic [YEAR_W-1:0]       ya, yb;
  logic [MONTH_W-1:0]      ma, mb;
  logic [DAY_W-1:0]        da, db;

  // Working registers
  logic [DOY_W-1:0]        doy;
  logic [ZR_W-1:0]         za, zb, zt;
  logic [YEAR_W-1:0]       acc;
  logic [BIT_W-1:0]        bit_idx;
  logic [YEAR_W-1:0]       y_r;
  logic [MONTH_W-1:0]      m_r;
  logic [DAY_W-1:0]        d_r;
  logic [DIFF_W-1:0]       diff_r;
  logic                    gt_r, eq_r, oor_r;

  // Output register
  logic                    out_valid;
  logic [YEAR_W-1:0]       out_year;
  logic [MONTH_W-1:0]      out_month;
  logic [DAY_W-1:0]        out_day;
  logic [DIFF_W-1:0]       out_diff;
  logic                    out_after, out_equal, out_oor;

  // Combinational helpers
  unit_res_t               unit_res;
  logic [YEAR_W-1:0]       unit_c;
  logic [YEAR_W-1:0]       cand;
  logic [YEAR_W-1:0]       sel_y, yy_calc;
  logic [MONTH_W-1:0]      sel_m, sel_mp;
  logic [DAY_W-1:0]        sel_d, sel_ml, d_sat;
  logic [DOY_W-1:0]        doy_calc;
  logic signed [Z_W-1:0]   z_sum;
  logic [MONTH_W-1:0]      md_mp, md_month;
  logic [DAY_W-1:0]        md_day;
  logic [YEAR_W-1:0]       md_year;
  logic                    out_free;

  function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] r;
    r = y;
    if (y < YEAR_MIN) r = YEAR_MIN;
    if (y > YEAR_MAX) r = YEAR_MAX;
    return r;
  endfunction

  function automatic logic [MONTH_W-1:0] sat_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m < MONTH_JAN) r = MONTH_JAN;
    if (m > MONTH_DEC) r = MONTH_DEC;
    return r;
  endfunction

  // Take no beat while reset is held
  assign cmd.ready = (state == S_IDLE) && !rst;
  assign out_free  = !out_valid || res.ready;

  // Shared day-count unit
  calda_unit u_unit (
    .clk (clk),
    .c   (unit_c),
    .res (unit_res)
  );

  // Decode the date in work: clamp the day, find its day of year
  always_comb begin
    sel_y    = (state == S_DB) ? yb : ya;
    sel_m    = (state == S_DB) ? mb : ma;
    sel_d    = (state == S_DB) ? db : da;
    sel_mp   = (sel_m >= MONTH_MAR) ? sel_m - MONTH_MAR : sel_m + MP_WRAP;
    sel_ml   = month_days(sel_m, unit_res.leap);
    if (sel_d < DAY_FIRST) begin
      d_sat = DAY_FIRST;
    end else if (sel_d > sel_ml) begin
      d_sat = sel_ml;
    end else begin
      d_sat = sel_d;
    end
    doy_calc = month_start(sel_mp) + DOY_W'(d_sat) - DOY_W'(DAY_FIRST);
    yy_calc  = sel_y - YEAR_W'(sel_m <= MONTH_FEB);
  end

  // Pick the operand of the day-count unit
  always_comb begin
    cand = acc | (YEAR_W'(1) << bit_idx);
    unique case (state)
      S_LA:    unit_c = ya;
      S_DA:    unit_c = yy_calc;
      S_FA:    unit_c = yb;
      S_DB:    unit_c = yy_calc;
      S_LOAD:  unit_c = cand;
      default: unit_c = acc;
    endcase
  end

  // Shifted raw day number
  assign z_sum = $signed({2'b00, za}) + $signed({off_r[OFF_W-1], off_r});

  // Split the day of year back into month and day
  always_comb begin
    md_mp = '0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(MONTH_W'(i))) md_mp = MONTH_W'(i);
    end
    md_day   = DAY_W'(doy - month_start(md_mp)) + DAY_FIRST;
    md_month = (md_mp < MP_JAN) ? md_mp + MONTH_MAR : md_mp - MP_WRAP;
    md_year  = acc + YEAR_W'(md_month <= MONTH_FEB);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd.valid) state_next = S_LA;
      S_LA:    state_next = S_DA;
      S_DA:    state_next = S_FA;
      S_FA:    state_next = S_DB;
      S_DB:    state_next = S_FB;
      S_FB:    state_next = S_CMP;
      S_CMP:   state_next = (op_r == OP_DIFF) ? S_DONE : S_LOAD;
      S_LOAD:  state_next = S_TEST;
      S_TEST:  state_next = (bit_idx == '0) ? S_FLOAD : S_LOAD;
      S_FLOAD: state_next = S_CONV;
      S_CONV:  state_next = S_MD;
      S_MD:    state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          op_r  <= op_t'(cmd.op);
          off_r <= cmd.offset;
          ya    <= sat_year(cmd.year_a);
          ma    <= sat_month(cmd.month_a);
          da    <= cmd.day_a;
          yb    <= sat_year(cmd.year_b);
          mb    <= sat_month(cmd.month_b);
          db    <= cmd.day_b;
        end
      end
      S_DA:   doy <= doy_calc;
      S_FA:   za  <= ZR_W'(unit_res.f + F_W'(doy));
      S_DB:   doy <= doy_calc;
      S_FB:   zb  <= ZR_W'(unit_res.f + F_W'(doy));
      S_CMP: begin
        gt_r <= (za > zb);
        eq_r <= (za == zb);
        if (op_r == OP_DIFF) begin
          diff_r <= DIFF_W'(za) - DIFF_W'(zb);
          y_r    <= '0;
          m_r    <= '0;
          d_r    <= '0;
          oor_r  <= 1'b0;
        end else begin
          diff_r  <= '0;
          acc     <= '0;
          bit_idx <= BIT_W'(YEAR_W - 1);
          // Pin the shifted date to the calendar ends
          if (z_sum < $signed({2'b00, RAW_MIN})) begin
            zt    <= RAW_MIN;
            oor_r <= 1'b1;
          end else if (z_sum > $signed({2'b00, RAW_MAX})) begin
            zt    <= RAW_MAX;
            oor_r <= 1'b1;
          end else begin
            zt    <= ZR_W'(z_sum);
            oor_r <= 1'b0;
          end
        end
      end
      S_TEST: begin
        // Keep the bit when the candidate year does not pass the day number
        if (unit_res.f <= F_W'(zt)) acc <= cand;
        bit_idx <= bit_idx - 1'b1;
      end
      S_CONV: doy <= DOY_W'(F_W'(zt) - unit_res.f);
      S_MD: begin
        y_r <= md_year;
        m_r <= md_month;
        d_r <= md_day;
      end
      default: ;
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_year  <= y_r;
      out_month <= m_r;
      out_day   <= d_r;
      out_diff  <= diff_r;
      out_after <= gt_r;
      out_equal <= eq_r;
      out_oor   <= oor_r;
    end
  end

  assign res.valid        = out_valid;
  assign res.year_out     = out_year;
  assign res.month_out    = out_month;
  assign res.day_out      = out_day;
  assign res.difference   = out_diff;
  assign res.a_after_b    = out_after;
  assign res.dates_equal  = out_equal;
  assign res.out_of_range = out_oor;

  // Checks
  `ASSERT_IMPLIES(a_oor_pinned, out_valid && out_oor,
    (out_year == YEAR_MIN && out_month == MONTH_JAN && out_day == DAY_FIRST) ||
    (out_year == YEAR_MAX && out_month == MONTH_DEC && out_day == DAY_LAST),
    "out of range result not pinned to a calendar end")
  `ASSERT_NEVER(a_equal_consistent,
    out_valid && out_equal && (out_after || out_diff != '0),
    "equal dates reported with order or distance")
  `ASSERT_IMPLIES(a_year_found, state == S_CONV, acc <= YEAR_MAX,
    "year search ran past the calendar")
  `ASSERT_IMPLIES(a_doy_bound, state == S_MD, doy <= DOY_MAX,
    "day of year beyond one year")
  `ASSERT_IMPLIES(a_load_from_done, $rose(out_valid), $past(state == S_DONE),
    "result raised outside the hand-off state")

endmodule

`default_nettype wire
